// ----- sv/gpe_pkg.sv -----
// Shared types and defaults for the GF(2) polynomial extended Euclid pipeline.
// No dependencies; used by gf2_poly_ext_euclid_inverse.
package gpe_pkg;

   localparam int FIELD_WIDTH    = 16;
   localparam int POLY_WIDTH     = 16;
   localparam int QUOTIENT_DEPTH = 16;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] poly_x;
      logic [FIELD_WIDTH-1:0] poly_y;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] coef_lower;
      logic [FIELD_WIDTH-1:0] coef_higher;
      logic [FIELD_WIDTH-1:0] poly_gcd;
   } rsp_type;

endpackage

// ----- sv/gf2_poly_ext_euclid_inverse.sv -----
// GF(2) polynomial extended Euclid pipeline: Bezout coefficients and gcd.
// Depends on gpe_pkg for the beat types and parameter defaults.

// Takes one beat per cycle while no result beat is stalled, and returns one
// result beat per input beat, in order. Stages: one ordering stage, a chain
// of 2*POLY_WIDTH reduction stages, each doing one shift-XOR step of the
// division (closing the division in the same stage when the remainder drops
// below the divisor), and the output register. The Bezout coefficients are
// built forward in the same stages, so no quotient is kept.
// The whole pipeline holds while a result beat is stalled.
module gf2_poly_ext_euclid_inverse #(
   parameter int POLY_WIDTH     = gpe_pkg::POLY_WIDTH,
   parameter int QUOTIENT_DEPTH = gpe_pkg::QUOTIENT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gpe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gpe_pkg::rsp_type rsp_data
);

   localparam int W     = POLY_WIDTH;
   localparam int DW    = $clog2(W);
   localparam int CW    = $clog2(QUOTIENT_DEPTH + 1);
   localparam int NSTEP = 2 * W;

   typedef struct packed {
      logic          valid;
      logic [W-1:0]  hi;
      logic [W-1:0]  lo;
      logic [W-1:0]  uc;
      logic [W-1:0]  ua;
      logic [W-1:0]  vc;
      logic [W-1:0]  va;
      logic [CW-1:0] cnt;
   } stage_type;

   function automatic logic [DW-1:0] deg_fn(logic [W-1:0] v);
      logic [DW-1:0] d;
      d = '0;
      for (int i = 0; i < W; i++) begin
         if (v[i]) d = DW'(i);
      end
      return d;
   endfunction

   function automatic logic active_fn(stage_type s);
      return (s.hi > W'(1)) && (s.lo > W'(1)) && (s.cnt < CW'(QUOTIENT_DEPTH));
   endfunction

   // One shift-XOR reduction; close the division once the remainder is below lo
   function automatic stage_type step_fn(stage_type s);
      stage_type     r;
      logic [DW-1:0] dl;
      logic [DW-1:0] sh;
      logic [W-1:0]  nh;
      r  = s;
      dl = deg_fn(s.lo);
      sh = deg_fn(s.hi) - dl;
      nh = s.hi ^ (s.lo << sh);
      if (active_fn(s)) begin
         r.ua = s.ua ^ (s.uc << sh);
         r.va = s.va ^ (s.vc << sh);
         if (deg_fn(nh) < dl) begin
            r.hi  = s.lo;
            r.lo  = nh;
            r.uc  = r.ua;
            r.ua  = s.uc;
            r.vc  = r.va;
            r.va  = s.vc;
            r.cnt = CW'(s.cnt + 1'b1);
         end else begin
            r.hi = nh;
         end
      end
      return r;
   endfunction

   stage_type        st_ff [NSTEP+1];
   stage_type        st_in [NSTEP+1];
   logic             rsp_valid_ff;
   gpe_pkg::rsp_type rsp_data_ff;
   gpe_pkg::rsp_type rsp_data_in;
   logic             advance;
   logic [W-1:0]     x;
   logic [W-1:0]     y;
   stage_type        last;

   // Hold every stage while a result beat waits
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Order the pair into higher and lower
   assign x = W'(req_data.poly_x);
   assign y = W'(req_data.poly_y);
   always_comb begin
      st_in[0].valid = req_valid;
      st_in[0].hi    = (x >= y) ? x : y;
      st_in[0].lo    = (x >= y) ? y : x;
      st_in[0].uc    = W'(1);
      st_in[0].ua    = '0;
      st_in[0].vc    = '0;
      st_in[0].va    = W'(1);
      st_in[0].cnt   = '0;
   end

   // Reduction chain
   for (genvar g = 1; g <= NSTEP; g++) begin : g_step
      assign st_in[g] = step_fn(st_ff[g-1]);
   end

   for (genvar g = 0; g <= NSTEP; g++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g].valid <= 1'b0;
         end else if (advance) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   // Pick the gcd from the final pair and drive the result beat
   assign last = st_ff[NSTEP];
   always_comb begin
      rsp_data_in.coef_lower  = gpe_pkg::FIELD_WIDTH'(last.uc);
      rsp_data_in.coef_higher = gpe_pkg::FIELD_WIDTH'(last.vc);
      if (last.hi == '0) begin
         rsp_data_in.poly_gcd = gpe_pkg::FIELD_WIDTH'(last.lo);
      end else if (last.lo == '0) begin
         rsp_data_in.poly_gcd = gpe_pkg::FIELD_WIDTH'(last.hi);
      end else begin
         rsp_data_in.poly_gcd = gpe_pkg::FIELD_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_chain_long_enough: assert property (@(posedge clock) disable iff (reset)
      last.valid |-> !active_fn(last))
      else $error("reduction chain too short for a division");

   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold_moves_nothing: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(last) && $stable(rsp_data_ff))
      else $error("pipeline moved while held");
`endif

endmodule
